/* sv/ppr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppr_pkg: shared constants and types of the pulse peak rate meter
// widths, register indexes, rate scale and the structs passed between units
// ----------------------------------------------------------------------------
package ppr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int THRESH_W    = 16;
   localparam int PERIOD_W    = 10;
   localparam int IDX_W       = 10;
   localparam int FRAME_CNT_W = 11;
   localparam int MAX_FRAME   = 1024;
   localparam int EVEN_W      = 10;
   localparam int TOTAL_W     = 11;
   localparam int BPM_W       = 18;
   localparam int NUM_W       = 30;
   localparam int DEN_W       = 20;
   localparam int MUL_STEPS   = PERIOD_W;
   localparam int MUL_STEP_W  = 4;
   localparam int DIV_STEP_W  = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_PERIOD  = 1'b1;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd2;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd50;

   // 60000 bpm*ms with four fractional bits
   localparam logic [NUM_W-1:0]   BPM_SCALE_Q4 = 30'd960000;
   localparam logic [BPM_W-1:0]   BPM_MAX      = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;
   localparam logic [EVEN_W-1:0]  EVEN_MAX     = '1;

   typedef struct packed {
      logic                valid;
      logic [IDX_W-1:0]    first_idx;
      logic [IDX_W-1:0]    last_idx;
      logic [EVEN_W-1:0]   even_count;
      logic [TOTAL_W-1:0]  total;
   } frame_sum_type;

   typedef struct packed {
      logic [BPM_W-1:0]    bpm;
      logic                rate_valid;
      logic [TOTAL_W-1:0]  peaks;
   } rate_res_type;

   typedef struct packed {
      logic idle;
      logic res_valid;
   } seq_status_type;

endpackage
`default_nettype wire

/* sv/ppr_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppr_if: sample and result channels of the pulse peak rate meter
// valid/ready handshake with the payload fields of one word
// ----------------------------------------------------------------------------
interface ppr_req_if;
   logic                         valid;
   logic                         ready;
   logic [ppr_pkg::SAMPLE_W-1:0] ir_sample;
   logic                         frame_end;

   modport source (output valid, output ir_sample, output frame_end, input ready);
   modport sink   (input valid, input ir_sample, input frame_end, output ready);
endinterface

interface ppr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ppr_pkg::BPM_W-1:0]   beats_per_minute_q4;
   logic                        rate_valid;
   logic [ppr_pkg::TOTAL_W-1:0] peaks_found;

   modport source (output valid, output beats_per_minute_q4, output rate_valid,
                   output peaks_found, input ready);
   modport sink   (input valid, input beats_per_minute_q4, input rate_valid,
                   input peaks_found, output ready);
endinterface
`default_nettype wire

/* sv/pulse_peak_rate_meter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_peak_rate_meter_unit: heart rate from frames of infrared samples
// detects peaks sample by sample and, at frame end, computes beats per
// minute in q4 with a bit-serial multiply and divide
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake        word
//  req_ch    in         valid/ready      ir_sample, frame_end
//  rsp_ch    out        valid/ready      beats_per_minute_q4, rate_valid,
//                                        peaks_found
//  csr_*     in         csr_wr_en only   csr_index, csr_wdata
//
//  sample words without frame_end are accepted back to back while the sequencer is idle
//  after a frame_end word ready stays low while the sequencer runs: on a frame
//  with too few peaks it goes straight to the hand-off, otherwise through the
//  shift-add steps set by the multiplier width, a load, the divide steps set by
//  the dividend width and the done flag, then the hand-off
//  the hand-off stalls while the output register holds a word not yet taken
//  the result sits in an output register; new samples flow while it waits
//  reset is synchronous; it clears the frame state and the result valid flag
//
module pulse_peak_rate_meter_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ppr_req_if.sink                              req_ch,
   ppr_rsp_if.source                            rsp_ch,
   input  wire logic                            csr_wr_en,
   input  wire logic [ppr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ppr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [ppr_pkg::THRESH_W-1:0] threshold_ff;
   logic [ppr_pkg::PERIOD_W-1:0] period_ff;

   // result register
   logic                         rsp_valid_ff;
   logic [ppr_pkg::BPM_W-1:0]    rsp_bpm_ff;
   logic                         rsp_rate_valid_ff;
   logic [ppr_pkg::TOTAL_W-1:0]  rsp_peaks_ff;

   logic                         req_accept;
   logic                         start;
   ppr_pkg::frame_sum_type       summary;
   ppr_pkg::seq_status_type      seq_status;
   ppr_pkg::rate_res_type        seq_result;
   logic                         load;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ppr_pkg::THRESH_RESET;
         period_ff    <= ppr_pkg::PERIOD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ppr_pkg::CSR_PEAK_THRESHOLD: threshold_ff <= csr_wdata;
            ppr_pkg::CSR_SAMPLE_PERIOD:  period_ff    <= csr_wdata[ppr_pkg::PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // samples only enter while the rate sequencer is free
   assign req_ch.ready = seq_status.idle;
   assign req_accept   = req_ch.valid && req_ch.ready;

   ppr_peak_track u_track (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .sample    (req_ch.ir_sample),
      .frame_end (req_ch.frame_end),
      .threshold (threshold_ff),
      .start     (start),
      .summary   (summary)
   );

   ppr_rate_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .summary (summary),
      .period  (period_ff),
      .take    (load),
      .status  (seq_status),
      .result  (seq_result)
   );

   // move a finished word into the output register when it is free or draining
   assign load = seq_status.res_valid && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load) begin
         rsp_bpm_ff        <= seq_result.bpm;
         rsp_rate_valid_ff <= seq_result.rate_valid;
         rsp_peaks_ff      <= seq_result.peaks;
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.beats_per_minute_q4 = rsp_bpm_ff;
   assign rsp_ch.rate_valid          = rsp_rate_valid_ff;
   assign rsp_ch.peaks_found         = rsp_peaks_ff;

`ifndef SYNTH
   // a closing word always hands the frame to the sequencer
   a_frame_end_starts: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.frame_end) |=> !seq_status.idle)
      else $error("frame end word did not start the rate sequencer");

   // an invalid rate word carries a zero rate
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_rate_valid_ff) |-> (rsp_bpm_ff == '0))
      else $error("invalid rate word with nonzero rate");

   // two even-numbered peaks imply at least three peaks in all
   a_valid_peaks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rate_valid_ff) |-> (rsp_peaks_ff >= ppr_pkg::TOTAL_W'(3)))
      else $error("valid rate with fewer than three peaks");
`endif

endmodule
`default_nettype wire

/* sv/ppr_peak_track.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppr_peak_track: per-sample peak detector
// keeps the sample window and the even-peak statistics of the open frame
// ----------------------------------------------------------------------------
module ppr_peak_track (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [ppr_pkg::SAMPLE_W-1:0] sample,
   input  wire logic                         frame_end,
   input  wire logic [ppr_pkg::THRESH_W-1:0] threshold,
   output      logic                         start,
   output      ppr_pkg::frame_sum_type       summary
);

   logic [ppr_pkg::SAMPLE_W-1:0]    older_ff, older_in;
   logic [ppr_pkg::SAMPLE_W-1:0]    middle_ff, middle_in;
   logic [ppr_pkg::FRAME_CNT_W-1:0] index_ff, index_in;
   logic [ppr_pkg::TOTAL_W-1:0]     total_ff, total_in;
   logic [ppr_pkg::IDX_W-1:0]       first_ff, first_in;
   logic [ppr_pkg::IDX_W-1:0]       last_ff, last_in;
   logic [ppr_pkg::EVEN_W-1:0]      even_ff, even_in;

   logic                            in_range;
   logic                            is_peak;
   logic [ppr_pkg::SAMPLE_W:0]      older_bar;
   logic [ppr_pkg::SAMPLE_W:0]      newer_bar;
   logic [ppr_pkg::IDX_W-1:0]       peak_idx;

   always_comb begin
      in_range  = index_ff < ppr_pkg::FRAME_CNT_W'(ppr_pkg::MAX_FRAME);
      older_bar = {1'b0, older_ff} + {1'b0, threshold};
      newer_bar = {1'b0, sample} + {1'b0, threshold};
      is_peak   = in_range && (index_ff >= ppr_pkg::FRAME_CNT_W'(2)) &&
                  ({1'b0, middle_ff} > older_bar) && ({1'b0, middle_ff} > newer_bar);
      peak_idx  = index_ff[ppr_pkg::IDX_W-1:0] - ppr_pkg::IDX_W'(1);

      older_in  = older_ff;
      middle_in = middle_ff;
      index_in  = index_ff;
      total_in  = total_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      even_in   = even_ff;

      if (in_range) begin
         older_in  = middle_ff;
         middle_in = sample;
         index_in  = index_ff + ppr_pkg::FRAME_CNT_W'(1);
      end
      if (is_peak) begin
         // only even-numbered peaks feed the rate
         if (!total_ff[0]) begin
            if (even_ff == '0) begin
               first_in = peak_idx;
            end
            last_in = peak_idx;
            if (even_ff != ppr_pkg::EVEN_MAX) begin
               even_in = even_ff + ppr_pkg::EVEN_W'(1);
            end
         end
         if (total_ff != ppr_pkg::TOTAL_MAX) begin
            total_in = total_ff + ppr_pkg::TOTAL_W'(1);
         end
      end

      start              = accept && frame_end;
      summary.valid      = even_in >= ppr_pkg::EVEN_W'(2);
      summary.first_idx  = first_in;
      summary.last_idx   = last_in;
      summary.even_count = even_in;
      summary.total      = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         older_ff  <= '0;
         middle_ff <= '0;
         index_ff  <= '0;
         total_ff  <= '0;
         first_ff  <= '0;
         last_ff   <= '0;
         even_ff   <= '0;
      end else if (accept) begin
         older_ff  <= older_in;
         middle_ff <= middle_in;
         index_ff  <= index_in;
         total_ff  <= total_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
         even_ff   <= even_in;
      end
   end

endmodule
`default_nettype wire

/* sv/ppr_serial_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppr_serial_div: bit-serial restoring divider
// one quotient bit per cycle, dividend shifted in msb first
// ----------------------------------------------------------------------------
module ppr_serial_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [ppr_pkg::NUM_W-1:0] dividend,
   input  wire logic [ppr_pkg::DEN_W-1:0] divisor,
   output      logic                      done,
   output      logic [ppr_pkg::NUM_W-1:0] quotient
);

   logic                           busy_ff;
   logic                           done_ff;
   logic [ppr_pkg::DIV_STEP_W-1:0] cnt_ff;
   logic [ppr_pkg::DEN_W-1:0]      rem_ff;
   logic [ppr_pkg::DEN_W-1:0]      den_ff;
   logic [ppr_pkg::NUM_W-1:0]      quo_ff;

   logic [ppr_pkg::DEN_W:0]        trial;
   logic [ppr_pkg::DEN_W:0]        diff;
   logic                           q_bit;

   always_comb begin
      trial = {rem_ff, quo_ff[ppr_pkg::NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      q_bit = !diff[ppr_pkg::DEN_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ppr_pkg::DIV_STEP_W'(ppr_pkg::NUM_W - 1);
            rem_ff  <= '0;
            den_ff  <= divisor;
            quo_ff  <= dividend;
         end else if (busy_ff) begin
            rem_ff <= q_bit ? diff[ppr_pkg::DEN_W-1:0] : trial[ppr_pkg::DEN_W-1:0];
            quo_ff <= {quo_ff[ppr_pkg::NUM_W-2:0], q_bit};
            cnt_ff <= cnt_ff - ppr_pkg::DIV_STEP_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

/* sv/ppr_rate_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppr_rate_seq: frame-end rate sequencer
// shift-add products for numerator and denominator, then serial divide
// ----------------------------------------------------------------------------
module ppr_rate_seq (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire ppr_pkg::frame_sum_type       summary,
   input  wire logic [ppr_pkg::PERIOD_W-1:0] period,
   input  wire logic                         take,
   output      ppr_pkg::seq_status_type      status,
   output      ppr_pkg::rate_res_type        result
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_LOAD,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   state_type                       state_ff;
   logic [ppr_pkg::MUL_STEP_W-1:0]  step_ff;
   logic [ppr_pkg::DEN_W-1:0]       span_sh_ff;
   logic [ppr_pkg::PERIOD_W-1:0]    per_sh_ff;
   logic [ppr_pkg::DEN_W-1:0]       den_ff;
   logic [ppr_pkg::NUM_W-1:0]       scale_sh_ff;
   logic [ppr_pkg::EVEN_W-1:0]      cnt_sh_ff;
   logic [ppr_pkg::NUM_W-1:0]       num_ff;
   logic                            valid_ff;
   logic [ppr_pkg::TOTAL_W-1:0]     total_ff;
   logic [ppr_pkg::BPM_W-1:0]       bpm_ff;

   logic                            div_done;
   logic [ppr_pkg::NUM_W-1:0]       div_quo;
   logic [ppr_pkg::BPM_W-1:0]       bpm_sat;

   ppr_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_LOAD),
      .dividend (num_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      if (|div_quo[ppr_pkg::NUM_W-1:ppr_pkg::BPM_W]) begin
         bpm_sat = ppr_pkg::BPM_MAX;
      end else begin
         bpm_sat = div_quo[ppr_pkg::BPM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  valid_ff <= summary.valid;
                  total_ff <= summary.total;
                  if (summary.valid) begin
                     span_sh_ff  <= ppr_pkg::DEN_W'(summary.last_idx - summary.first_idx);
                     per_sh_ff   <= (period == '0) ? ppr_pkg::PERIOD_W'(1) : period;
                     scale_sh_ff <= ppr_pkg::BPM_SCALE_Q4;
                     cnt_sh_ff   <= summary.even_count - ppr_pkg::EVEN_W'(1);
                     den_ff      <= '0;
                     num_ff      <= '0;
                     step_ff     <= '0;
                     state_ff    <= ST_MULT;
                  end else begin
                     bpm_ff   <= '0;
                     state_ff <= ST_HOLD;
                  end
               end
            end
            ST_MULT: begin
               if (per_sh_ff[0]) begin
                  den_ff <= den_ff + span_sh_ff;
               end
               if (cnt_sh_ff[0]) begin
                  num_ff <= num_ff + scale_sh_ff;
               end
               span_sh_ff  <= {span_sh_ff[ppr_pkg::DEN_W-2:0], 1'b0};
               scale_sh_ff <= {scale_sh_ff[ppr_pkg::NUM_W-2:0], 1'b0};
               per_sh_ff   <= {1'b0, per_sh_ff[ppr_pkg::PERIOD_W-1:1]};
               cnt_sh_ff   <= {1'b0, cnt_sh_ff[ppr_pkg::EVEN_W-1:1]};
               step_ff     <= step_ff + ppr_pkg::MUL_STEP_W'(1);
               if (step_ff == ppr_pkg::MUL_STEP_W'(ppr_pkg::MUL_STEPS - 1)) begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  bpm_ff   <= bpm_sat;
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign status.idle       = state_ff == ST_IDLE;
   assign status.res_valid  = state_ff == ST_HOLD;
   assign result.bpm        = bpm_ff;
   assign result.rate_valid = valid_ff;
   assign result.peaks      = total_ff;

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pulse_peak_rate_meter_unit
// streams frames of infrared sample words into the meter, predicts the rate
// word of every frame in-bench and compares it field by field on the result
// channel, with random idle bursts on both sides and several register settings
// ----------------------------------------------------------------------------
module tb;

   localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all
   localparam int SETTLE_CYCLES = 50;    // settle time after the last rate word
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_WORDS   = 50;

   typedef struct packed {
      logic [ppr_pkg::SAMPLE_W-1:0] ir;
      logic                         last;
   } sample_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_wr_en;
   logic [ppr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ppr_pkg::CSR_DATA_W-1:0]  csr_wdata;

   ppr_req_if req_ch ();
   ppr_rsp_if rsp_ch ();

   pulse_peak_rate_meter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // stimulus and expectations
   sample_word_type        pending_words[$];
   ppr_pkg::rate_res_type  expected_rates[$];
   bit           idle_enable = 1'b1;
   int           mismatches  = 0;
   int           quiet_cycles = 0;
   int           send_gap;
   int           recv_stall;

   // register copies as the meter should hold them
   int shadow_threshold = ppr_pkg::THRESH_RESET;
   int shadow_period    = ppr_pkg::PERIOD_RESET;

   // frame state of the predicted meter
   int pred_older, pred_middle, pred_index;
   int peak_total, first_even, last_even, even_count;

   task automatic clear_predicted_frame();
      pred_older  = 0;
      pred_middle = 0;
      pred_index  = 0;
      peak_total  = 0;
      first_even  = 0;
      last_even   = 0;
      even_count  = 0;
   endtask

   // advance the predicted meter by one accepted sample word
   task automatic meter_predict(input logic [ppr_pkg::SAMPLE_W-1:0] ir, input logic last);
      ppr_pkg::rate_res_type res;
      longint       per, den, quo;
      int           cur;
      cur = int'(ir);
      // samples past the frame capacity are dropped, frame_end still counts
      if (pred_index < ppr_pkg::MAX_FRAME) begin
         if (pred_index >= 2 && pred_middle > pred_older + shadow_threshold &&
             pred_middle > cur + shadow_threshold) begin
            // only even-numbered peaks feed the rate
            if ((peak_total & 1) == 0) begin
               if (even_count == 0) first_even = pred_index - 1;
               last_even = pred_index - 1;
               if (even_count < ppr_pkg::EVEN_MAX) even_count++;
            end
            if (peak_total < ppr_pkg::TOTAL_MAX) peak_total++;
         end
         pred_older  = pred_middle;
         pred_middle = cur;
         pred_index++;
      end
      if (last) begin
         res.rate_valid = (even_count >= 2);
         res.peaks      = ppr_pkg::TOTAL_W'(peak_total);
         res.bpm        = '0;
         if (res.rate_valid) begin
            // a zero period counts as one millisecond
            per = (shadow_period == 0) ? 1 : shadow_period;
            den = longint'(last_even - first_even) * per;
            if (den == 0) quo = ppr_pkg::BPM_MAX;
            else quo = (longint'(ppr_pkg::BPM_SCALE_Q4) * longint'(even_count - 1)) / den;
            if (quo > ppr_pkg::BPM_MAX) quo = ppr_pkg::BPM_MAX;
            res.bpm = ppr_pkg::BPM_W'(quo);
         end
         expected_rates = {expected_rates, res};
         clear_predicted_frame();
      end
   endtask

   task automatic note_mismatch(input string field, input longint want, input longint got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
   endtask

   task automatic check_rate(input ppr_pkg::rate_res_type got);
      ppr_pkg::rate_res_type want;
      if (expected_rates.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: rate word with none expected: bpm %0d valid %0d peaks %0d",
                     $realtime, got.bpm, got.rate_valid, got.peaks);
         return;
      end
      want = expected_rates.pop_front();
      if (got.bpm !== want.bpm) note_mismatch("beats_per_minute_q4", want.bpm, got.bpm);
      if (got.rate_valid !== want.rate_valid)
         note_mismatch("rate_valid", want.rate_valid, got.rate_valid);
      if (got.peaks !== want.peaks) note_mismatch("peaks_found", want.peaks, got.peaks);
   endtask

   // sample driver: a new word only once the current one is taken
   always @(posedge clock) begin : drive_samples
      sample_word_type next_word;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap     <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (send_gap != 0) begin
            req_ch.valid <= 1'b0;
            send_gap     <= send_gap - 1;
         end else if (idle_enable && $urandom_range(0, 15) == 0) begin
            // idle burst of random length
            req_ch.valid <= 1'b0;
            send_gap     <= $urandom_range(0, 8);
         end else if (pending_words.size() != 0) begin
            next_word = pending_words.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.ir_sample <= next_word.ir;
            req_ch.frame_end <= next_word.last;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // every accepted sample word updates the prediction
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         meter_predict(req_ch.ir_sample, req_ch.frame_end);
   end

   // result monitor with its own stall bursts
   always @(posedge clock) begin : watch_rates
      ppr_pkg::rate_res_type got;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_stall   <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.bpm        = rsp_ch.beats_per_minute_q4;
            got.rate_valid = rsp_ch.rate_valid;
            got.peaks      = rsp_ch.peaks_found;
            check_rate(got);
         end
         if (recv_stall != 0) begin
            rsp_ch.ready <= 1'b0;
            recv_stall   <= recv_stall - 1;
         end else if (idle_enable && $urandom_range(0, 15) == 0) begin
            rsp_ch.ready <= 1'b0;
            recv_stall   <= $urandom_range(0, 8);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog: count cycles in which neither channel moves a word
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic queue_word(input int ir, input bit last);
      sample_word_type w;
      w.ir   = ppr_pkg::SAMPLE_W'(ir);
      w.last = last;
      pending_words = {pending_words, w};
   endtask

   // pulse-like frame: raised samples at a steady spacing over a jittered base
   task automatic queue_pulse_frame(input int len);
      int spacing, offset, height, base, jit_max, s;
      spacing = $urandom_range(2, 12);
      offset  = $urandom_range(0, spacing - 1);
      height  = shadow_threshold + 1 + $urandom_range(0, 3000);
      if (height > 65535) height = 65535;
      base    = $urandom_range(0, 65535 - height);
      jit_max = height - shadow_threshold - 1;
      if (jit_max < 0) jit_max = 0;
      for (int i = 0; i < len; i++) begin
         // now and then a beat goes missing
         if (i % spacing == offset && $urandom_range(0, 19) != 0) s = base + height;
         else s = base + $urandom_range(0, jit_max);
         queue_word(s, i == len - 1);
      end
   endtask

   task automatic queue_noise_frame(input int len);
      for (int i = 0; i < len; i++)
         queue_word($urandom_range(0, 65535), i == len - 1);
   endtask

   // mostly pulse frames, some noise and one- or two-sample frames
   task automatic queue_random_phase(input int n_words);
      int made, len, kind;
      made = 0;
      while (made < n_words) begin
         kind = $urandom_range(0, 9);
         if (kind == 9) len = $urandom_range(1, 2);
         else len = $urandom_range(3, 40);
         if (kind >= 8) queue_noise_frame(len);
         else queue_pulse_frame(len);
         made += len;
      end
   endtask

   task automatic write_csr(input logic [ppr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ppr_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == ppr_pkg::CSR_PEAK_THRESHOLD) shadow_threshold = int'(data);
      else shadow_period = int'(data[ppr_pkg::PERIOD_W-1:0]);
   endtask

   // upper write-data bits of the period are junk, the register keeps 10 bits
   task automatic apply_setting(input int thr, input int per);
      logic [ppr_pkg::CSR_DATA_W-1:0] data;
      write_csr(ppr_pkg::CSR_PEAK_THRESHOLD, ppr_pkg::CSR_DATA_W'(thr));
      data = ppr_pkg::CSR_DATA_W'($urandom());
      data[ppr_pkg::PERIOD_W-1:0] = ppr_pkg::PERIOD_W'(per);
      write_csr(ppr_pkg::CSR_SAMPLE_PERIOD, data);
   endtask

   // sender holds off until every rate word is back, then the divider settles
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_ch.valid || expected_rates.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   int thr_plan[7];
   int per_plan[7];

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.ir_sample = '0;
      req_ch.frame_end = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = ppr_pkg::CSR_PEAK_THRESHOLD;
      csr_wdata        = '0;
      clear_predicted_frame();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed frames at the reset settings
      queue_word(65535, 1);                   // one-sample frame
      queue_word(0, 0);                       // two-sample frame, last never tested
      queue_word(65535, 1);
      for (int i = 0; i < 7; i++)             // three peaks, two even ones
         queue_word((i % 2) ? 65535 : 0, i == 6);
      queue_word(10, 0);                      // margin equal to threshold, then one over
      queue_word(12, 0);
      queue_word(10, 0);
      queue_word(13, 0);
      queue_word(10, 1);
      for (int i = 0; i < 3; i++)             // flat at full scale
         queue_word(65535, i == 2);
      queue_word(0, 0);                       // high last sample is not a peak
      queue_word(0, 0);
      queue_word(65535, 1);
      wait_idle();

      // register settings, extremes and zero period among them
      thr_plan = '{0, 65535, 0, 2, $urandom_range(0, 4000), $urandom_range(0, 4000), 5};
      per_plan = '{1, 1023, 0, 1000, $urandom_range(0, 1023), $urandom_range(0, 1023), 50};
      for (int p = 0; p < 7; p++) begin
         apply_setting(thr_plan[p], per_plan[p]);
         if (p == 6) idle_enable = 1'b0;      // closing stretch runs flat out
         queue_random_phase(PHASE_WORDS);
         if (p == 2) queue_pulse_frame($urandom_range(1030, 1060));  // overlong frame
         wait_idle();
      end

      mismatches += expected_rates.size();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* pulse_peak_rate_meter_unit.f */
sv/ppr_pkg.sv
sv/ppr_if.sv
sv/ppr_peak_track.sv
sv/ppr_serial_div.sv
sv/ppr_rate_seq.sv
sv/pulse_peak_rate_meter_unit.sv
test/tb.sv
